FILE: rtl/svg_pkg.sv
// Shared types and fixed-point constants for the star vertex generator.
package svg_pkg;

  typedef struct packed {
    logic signed [23:0] center_x;
    logic signed [23:0] center_y;
    logic        [15:0] outer_radius;
    logic        [5:0]  point_count;
  } star_req_t;

  typedef struct packed {
    logic signed [23:0] vertex_x;
    logic signed [23:0] vertex_y;
    logic        [5:0]  vertex_number;
    logic               is_inner;
    logic               last;
  } vertex_t;

  typedef struct packed {
    logic               done;
    logic signed [15:0] value;
  } sine_rsp_t;

  localparam logic [15:0] INNER_SCALE_RESET = 16'd26214;

  // pi/2 in Q2.30
  localparam logic [30:0] PIH30    = 31'd1686629713;
  localparam logic [30:0] Q30_ONE  = 31'd1073741824;
  localparam int          HORNER_STEPS = 4;

  // Horner divisors and floor(2^32 / d)
  localparam logic [6:0]  HORNER_DIV   [HORNER_STEPS] = '{7'd72, 7'd42, 7'd20, 7'd6};
  localparam logic [29:0] HORNER_RECIP [HORNER_STEPS] =
    '{30'd59652323, 30'd102261126, 30'd214748364, 30'd715827882};

  localparam logic signed [25:0] COORD_MAX = 26'sd8388607;
  localparam logic signed [25:0] COORD_MIN = -26'sd8388608;

endpackage

FILE: rtl/svg_ram.sv
// Generic single-write, single-read RAM with registered read data.
module svg_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: rtl/svg_sine.sv
// Iterative Q1.15 sine of a turn fraction: fold, scale to radians, Taylor Horner steps.
module svg_sine import svg_pkg::*; #(
  parameter int ANGLE_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [ANGLE_BITS-1:0] angle_i,
  output sine_rsp_t             rsp_o
);

  localparam int SHIFT = ANGLE_BITS - 2;
  localparam int TW    = ANGLE_BITS - 1;
  localparam logic [TW-1:0] QUARTER = TW'(1) << SHIFT;

  typedef enum logic [2:0] {
    ST_IDLE, ST_X, ST_X2, ST_MUL, ST_REC, ST_FIX, ST_OUT
  } state_e;

  state_e             state_q;
  logic               neg_q;
  logic [TW-1:0]      t_q;
  logic [30:0]        x_q;
  logic [31:0]        x2_q;
  logic [30:0]        term_q;
  logic [31:0]        v_q;
  logic [29:0]        qe_q;
  logic [1:0]         step_q;
  logic signed [15:0] val_q;
  logic               done_q;

  logic [1:0]         quad;
  logic [TW-1:0]      rpart;
  logic [TW-1:0]      t_d;
  logic [TW+30:0]     prod_x;
  logic [61:0]        prod_xx;
  logic [62:0]        prod_v;
  logic [61:0]        prod_r;
  logic [36:0]        qd_full;
  logic [31:0]        rem;
  logic [31:0]        qfix;
  logic [61:0]        prod_s;
  logic [31:0]        s_round;
  logic [16:0]        s15;
  logic [15:0]        mag;

  always_comb begin
    quad    = angle_i[ANGLE_BITS-1 -: 2];
    rpart   = {1'b0, angle_i[SHIFT-1:0]};
    t_d     = quad[0] ? (QUARTER - rpart) : rpart;
    prod_x  = t_q * PIH30;
    prod_xx = x_q * x_q;
    prod_v  = x2_q * term_q;
    prod_r  = v_q * HORNER_RECIP[step_q];
    qd_full = qe_q * HORNER_DIV[step_q];
    rem     = v_q - qd_full[31:0];
    qfix    = {2'b00, qe_q} + ((rem >= {25'd0, HORNER_DIV[step_q]}) ? 32'd1 : 32'd0);
    prod_s  = x_q * term_q;
    s_round = {1'b0, prod_s[60:30]} + 32'd16384;
    s15     = s_round[31:15];
    mag     = (s15 > 17'd32767) ? 16'd32767 : s15[15:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      neg_q   <= 1'b0;
      t_q     <= '0;
      x_q     <= '0;
      x2_q    <= '0;
      term_q  <= '0;
      v_q     <= '0;
      qe_q    <= '0;
      step_q  <= '0;
      val_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (start_i) begin
            t_q     <= t_d;
            neg_q   <= quad[1];
            state_q <= ST_X;
          end
        end
        ST_X: begin
          x_q     <= prod_x[SHIFT+30:SHIFT];
          state_q <= ST_X2;
        end
        ST_X2: begin
          x2_q    <= prod_xx[61:30];
          term_q  <= Q30_ONE;
          step_q  <= '0;
          state_q <= ST_MUL;
        end
        ST_MUL: begin
          v_q     <= prod_v[61:30];
          state_q <= ST_REC;
        end
        ST_REC: begin
          qe_q    <= prod_r[61:32];
          state_q <= ST_FIX;
        end
        ST_FIX: begin
          term_q <= Q30_ONE - qfix[30:0];
          step_q <= step_q + 2'd1;
          state_q <= (step_q == 2'(HORNER_STEPS - 1)) ? ST_OUT : ST_MUL;
        end
        ST_OUT: begin
          val_q   <= neg_q ? -$signed(mag) : $signed(mag);
          done_q  <= 1'b1;
          state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign rsp_o.done  = done_q;
  assign rsp_o.value = val_q;

endmodule

FILE: rtl/star_vertex_generator.sv
// Star vertex generator: 2n vertices per request, computed into a RAM, then emitted in a burst.
// Per request: accept, a bit-serial divider for the angle step, then per vertex two sine units
// in parallel, offset, sum and RAM write; then the burst, one vertex per cycle, read through
// the RAM's registered read port. A new request is taken only once the burst is through.
// The receiver cannot stall results.
// Reset: asynchronous, active low; inner_scale returns to 0.4, the block goes idle.
module star_vertex_generator import svg_pkg::*; #(
  parameter int MAX_POINTS = 32,
  parameter int ANGLE_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  star_req_t   req_i,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  output logic        result_strobe_o,
  output vertex_t     result_o
);

  localparam int AW = $clog2(2 * MAX_POINTS);
  localparam int CW = $clog2(ANGLE_BITS + 1);
  localparam logic [ANGLE_BITS-1:0] QUARTER = ANGLE_BITS'(1) << (ANGLE_BITS - 2);

  typedef enum logic [2:0] {
    ST_IDLE, ST_DIV, ST_VSTART, ST_VWAIT, ST_OFF, ST_SUM, ST_EMIT
  } state_e;

  state_e                 state_q;
  logic [15:0]            inner_scale_q;
  logic signed [23:0]     cx_q;
  logic signed [23:0]     cy_q;
  logic [15:0]            outer_q;
  logic [15:0]            inner_q;
  logic [6:0]             total_q;
  logic [CW-1:0]          cnt_q;
  logic [ANGLE_BITS-1:0]  step_q;
  logic [6:0]             rem_q;
  logic [ANGLE_BITS-1:0]  a_q;
  logic [6:0]             arem_q;
  logic [5:0]             k_q;
  logic [5:0]             e_q;
  logic signed [17:0]     off_x_q;
  logic signed [17:0]     off_y_q;
  logic                   strobe_q;
  logic [5:0]             num_q;
  logic                   last_q;

  logic [5:0]             n_cl;
  logic [31:0]            inner_prod;
  logic [6:0]             div_sh;
  logic                   div_ge;
  logic [7:0]             arem_sum;
  logic                   arem_ge;
  logic [15:0]            rad;
  logic [15:0]            mag_x;
  logic [15:0]            mag_y;
  logic [30:0]            prod_ox;
  logic [30:0]            prod_oy;
  logic [31:0]            rnd_x;
  logic [31:0]            rnd_y;
  logic signed [17:0]     off_x_d;
  logic signed [17:0]     off_y_d;
  logic signed [25:0]     sum_x;
  logic signed [25:0]     sum_y;
  logic signed [23:0]     sat_x;
  logic signed [23:0]     sat_y;
  logic                   k_last;
  logic                   e_last;

  sine_rsp_t              sin_rsp;
  sine_rsp_t              cos_rsp;
  logic                   sine_start;
  logic                   ram_we;
  logic [47:0]            ram_rdata;

  assign busy       = (state_q != ST_IDLE);
  assign sine_start = (state_q == ST_VSTART);
  assign ram_we     = (state_q == ST_SUM);

  always_comb begin
    n_cl       = (req_i.point_count > 6'(MAX_POINTS)) ? 6'(MAX_POINTS) : req_i.point_count;
    inner_prod = req_i.outer_radius * inner_scale_q + 32'd32768;
    div_sh     = {rem_q[5:0], (cnt_q == CW'(ANGLE_BITS))};
    div_ge     = (div_sh >= total_q);
    arem_sum   = {1'b0, arem_q} + {1'b0, rem_q};
    arem_ge    = (arem_sum >= {1'b0, total_q});
    k_last     = ({1'b0, k_q} == total_q - 7'd1);
    e_last     = ({1'b0, e_q} == total_q - 7'd1);

    rad     = k_q[0] ? inner_q : outer_q;
    mag_x   = sin_rsp.value[15] ? 16'(-sin_rsp.value) : sin_rsp.value;
    mag_y   = cos_rsp.value[15] ? 16'(-cos_rsp.value) : cos_rsp.value;
    prod_ox = rad * mag_x[14:0];
    prod_oy = rad * mag_y[14:0];
    rnd_x   = {1'b0, prod_ox} + 32'd16384;
    rnd_y   = {1'b0, prod_oy} + 32'd16384;
    off_x_d = sin_rsp.value[15] ? -$signed({1'b0, rnd_x[31:15]}) : $signed({1'b0, rnd_x[31:15]});
    off_y_d = cos_rsp.value[15] ? -$signed({1'b0, rnd_y[31:15]}) : $signed({1'b0, rnd_y[31:15]});

    sum_x = {{2{cx_q[23]}}, cx_q} + {{8{off_x_q[17]}}, off_x_q};
    sum_y = {{2{cy_q[23]}}, cy_q} - {{8{off_y_q[17]}}, off_y_q};
    if (sum_x > COORD_MAX) begin
      sat_x = COORD_MAX[23:0];
    end else if (sum_x < COORD_MIN) begin
      sat_x = COORD_MIN[23:0];
    end else begin
      sat_x = sum_x[23:0];
    end
    if (sum_y > COORD_MAX) begin
      sat_y = COORD_MAX[23:0];
    end else if (sum_y < COORD_MIN) begin
      sat_y = COORD_MIN[23:0];
    end else begin
      sat_y = sum_y[23:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inner_scale_q <= INNER_SCALE_RESET;
    end else if (cfg_we_i) begin
      inner_scale_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      cx_q     <= '0;
      cy_q     <= '0;
      outer_q  <= '0;
      inner_q  <= '0;
      total_q  <= '0;
      cnt_q    <= '0;
      step_q   <= '0;
      rem_q    <= '0;
      a_q      <= '0;
      arem_q   <= '0;
      k_q      <= '0;
      e_q      <= '0;
      off_x_q  <= '0;
      off_y_q  <= '0;
      strobe_q <= 1'b0;
      num_q    <= '0;
      last_q   <= 1'b0;
    end else begin
      strobe_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (start && n_cl != 6'd0) begin
            cx_q    <= req_i.center_x;
            cy_q    <= req_i.center_y;
            outer_q <= req_i.outer_radius;
            inner_q <= inner_prod[31:16];
            total_q <= {n_cl, 1'b0};
            cnt_q   <= CW'(ANGLE_BITS);
            step_q  <= '0;
            rem_q   <= '0;
            a_q     <= '0;
            arem_q  <= {1'b0, n_cl};
            k_q     <= '0;
            state_q <= ST_DIV;
          end
        end
        // step = 2^ANGLE_BITS / 2n, one quotient bit per cycle
        ST_DIV: begin
          rem_q  <= div_ge ? (div_sh - total_q) : div_sh;
          step_q <= {step_q[ANGLE_BITS-2:0], div_ge};
          cnt_q  <= cnt_q - CW'(1);
          if (cnt_q == '0) begin
            state_q <= ST_VSTART;
          end
        end
        ST_VSTART: begin
          state_q <= ST_VWAIT;
        end
        ST_VWAIT: begin
          if (sin_rsp.done && cos_rsp.done) begin
            state_q <= ST_OFF;
          end
        end
        ST_OFF: begin
          off_x_q <= off_x_d;
          off_y_q <= off_y_d;
          state_q <= ST_SUM;
        end
        ST_SUM: begin
          a_q    <= a_q + step_q + (arem_ge ? ANGLE_BITS'(1) : ANGLE_BITS'(0));
          arem_q <= arem_ge ? 7'(arem_sum - {1'b0, total_q}) : arem_sum[6:0];
          if (k_last) begin
            e_q     <= '0;
            state_q <= ST_EMIT;
          end else begin
            k_q     <= k_q + 6'd1;
            state_q <= ST_VSTART;
          end
        end
        ST_EMIT: begin
          strobe_q <= 1'b1;
          num_q    <= e_q;
          last_q   <= e_last;
          if (e_last) begin
            state_q <= ST_IDLE;
          end else begin
            e_q <= e_q + 6'd1;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  svg_sine #(
    .ANGLE_BITS(ANGLE_BITS)
  ) u_sin (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(sine_start),
    .angle_i(a_q),
    .rsp_o  (sin_rsp)
  );

  svg_sine #(
    .ANGLE_BITS(ANGLE_BITS)
  ) u_cos (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(sine_start),
    .angle_i(a_q + QUARTER),
    .rsp_o  (cos_rsp)
  );

  svg_ram #(
    .WIDTH(48),
    .DEPTH(2 * MAX_POINTS)
  ) u_vertex_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(k_q[AW-1:0]),
    .wdata_i({sat_x, sat_y}),
    .raddr_i(e_q[AW-1:0]),
    .rdata_o(ram_rdata)
  );

  assign result_strobe_o        = strobe_q;
  assign result_o.vertex_x      = ram_rdata[47:24];
  assign result_o.vertex_y      = ram_rdata[23:0];
  assign result_o.vertex_number = num_q;
  assign result_o.is_inner      = num_q[0];
  assign result_o.last          = last_q;

`ifndef SYNTH
  a_strobe_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe_o |-> $past(state_q == ST_EMIT))
    else $error("result strobe without a RAM read");

  a_write_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> ({1'b0, k_q} < total_q))
    else $error("vertex write beyond request");

  a_sine_done_waited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sin_rsp.done |-> (state_q == ST_VWAIT) && cos_rsp.done)
    else $error("sine result not awaited");

  a_last_ends_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_strobe_o && result_o.last) |=> !result_strobe_o)
    else $error("strobe after last vertex");
`endif

endmodule

FILE: sim/star_vertex_checker.sv
// Watches the star request, config and vertex channels, predicts every vertex and checks it.
module star_vertex_checker import svg_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        busy_i,
  input  star_req_t   req_i,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        result_strobe_i,
  input  vertex_t     result_i,
  output int          pending_o,
  output int          fail_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_POINTS = 32;
  localparam int ANGLE_BITS = 16;
  localparam bit [63:0] QUARTER_TURN = 64'd1 << (ANGLE_BITS - 2);
  localparam bit [63:0] ANGLE_MASK = (64'd1 << ANGLE_BITS) - 1;
  localparam bit [63:0] ONE_Q30 = 64'd1 << 30;

  logic [15:0] inner_scale = INNER_SCALE_RESET;
  vertex_t     expected_vertices[$];
  vertex_t     want;
  int          fails = 0;

  // sine of a turn fraction, Q1.15, Taylor series in Q30
  function automatic int turn_sine(bit [63:0] ang);
    bit [63:0] m, r, t, x, x2, term, s30, s15;
    bit [63:0] divs[4] = '{64'd72, 64'd42, 64'd20, 64'd6};
    bit [1:0]  quad;
    m    = ang & ANGLE_MASK;
    quad = m[ANGLE_BITS-1 -: 2];
    r    = m & (QUARTER_TURN - 1);
    t    = quad[0] ? (QUARTER_TURN - r) : r;
    x    = (t * 64'd1686629713) >> (ANGLE_BITS - 2);
    x2   = (x * x) >> 30;
    term = ONE_Q30;
    for (int i = 0; i < 4; i++) begin
      term = ONE_Q30 - ((x2 * term) >> 30) / divs[i];
    end
    s30 = (x * term) >> 30;
    s15 = (s30 + 64'd16384) >> 15;
    if (s15 > 64'd32767) s15 = 64'd32767;
    return quad[1] ? -int'(s15) : int'(s15);
  endfunction

  function automatic longint radial_offset(bit [63:0] rad, int s);
    bit [63:0] mag;
    longint    off;
    mag = (s < 0) ? 64'(-s) : 64'(s);
    off = longint'((rad * mag + 64'd16384) >> 15);
    return (s < 0) ? -off : off;
  endfunction

  function automatic logic signed [23:0] clamp_coord(longint v);
    if (v > 64'sd8388607) return 24'sh7FFFFF;
    if (v < -64'sd8388608) return 24'sh800000;
    return v[23:0];
  endfunction

  function automatic void plot_star(star_req_t req);
    longint    cx, cy;
    bit [63:0] n, total, outer, inner, ang, rad;
    int        sn, cs;
    vertex_t   v;
    cx    = {{40{req.center_x[23]}}, req.center_x};
    cy    = {{40{req.center_y[23]}}, req.center_y};
    outer = 64'(req.outer_radius);
    n     = 64'(req.point_count);
    if (n > MAX_POINTS) n = MAX_POINTS;
    if (n == 0) return;
    inner = (outer * 64'(inner_scale) + 64'd32768) >> 16;
    total = 2 * n;
    for (bit [63:0] k = 0; k < total; k++) begin
      ang = (((k << ANGLE_BITS) + n) / total) & ANGLE_MASK;
      sn  = turn_sine(ang);
      cs  = turn_sine(ang + QUARTER_TURN);
      rad = k[0] ? inner : outer;
      v.vertex_x      = clamp_coord(cx + radial_offset(rad, sn));
      v.vertex_y      = clamp_coord(cy - radial_offset(rad, cs));
      v.vertex_number = k[5:0];
      v.is_inner      = k[0];
      v.last          = (k == total - 1);
      expected_vertices.push_back(v);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inner_scale = INNER_SCALE_RESET;
      expected_vertices.delete();
    end else begin
      // a request taken on the same edge as a write still sees the old scale
      if (start_i && !busy_i) plot_star(req_i);
      if (cfg_we_i) inner_scale = cfg_wdata_i;
      if (result_strobe_i) begin
        if (expected_vertices.size() == 0) begin
          if (fails < 10)
            $display("%t: unexpected vertex x=%0d y=%0d k=%0d", $realtime,
                     result_i.vertex_x, result_i.vertex_y, result_i.vertex_number);
          fails++;
        end else begin
          want = expected_vertices.pop_front();
          if (result_i.vertex_x !== want.vertex_x || result_i.vertex_y !== want.vertex_y ||
              result_i.vertex_number !== want.vertex_number ||
              result_i.is_inner !== want.is_inner || result_i.last !== want.last) begin
            if (fails < 10) begin
              $display("%t: vertex mismatch, expected x=%0d y=%0d k=%0d inner=%0b last=%0b",
                       $realtime, want.vertex_x, want.vertex_y, want.vertex_number,
                       want.is_inner, want.last);
              $display("%t:                 actual   x=%0d y=%0d k=%0d inner=%0b last=%0b",
                       $realtime, result_i.vertex_x, result_i.vertex_y,
                       result_i.vertex_number, result_i.is_inner, result_i.last);
            end
            fails++;
          end
        end
      end
    end
    pending_o    <= expected_vertices.size();
    fail_count_o <= fails;
  end

endmodule

FILE: sim/star_vertex_generator_tb.sv
// Testbench top: drives star requests and inner scale writes, gives the verdict.
module star_vertex_generator_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import svg_pkg::*;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  star_req_t   star_req = '0;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;
  logic        vertex_strobe;
  vertex_t     vertex;
  int          pending;
  int          fail_count;

  star_vertex_generator i_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .start          (start),
    .busy           (busy),
    .req_i          (star_req),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .result_strobe_o(vertex_strobe),
    .result_o       (vertex)
  );

  star_vertex_checker i_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .start_i        (start),
    .busy_i         (busy),
    .req_i          (star_req),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .result_strobe_i(vertex_strobe),
    .result_i       (vertex),
    .pending_o      (pending),
    .fail_count_o   (fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #30ms;
    $display("TB_ERROR");
    $finish;
  end

  function automatic star_req_t make_star(logic [23:0] cx, logic [23:0] cy,
                                          logic [15:0] r, logic [5:0] n);
    star_req_t s;
    s.center_x     = cx;
    s.center_y     = cy;
    s.outer_radius = r;
    s.point_count  = n;
    return s;
  endfunction

  function automatic logic [23:0] random_coord();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return 24'h7FFFFF - 24'($urandom_range(0, 70000));
    if (pick == 1) return 24'h800000 + 24'($urandom_range(0, 70000));
    return 24'($urandom);
  endfunction

  function automatic star_req_t random_star();
    int          pick;
    logic [15:0] r;
    logic [5:0]  n;
    pick = $urandom_range(0, 99);
    if (pick < 70)      n = 6'($urandom_range(1, 8));
    else if (pick < 85) n = 6'($urandom_range(9, 20));
    else if (pick < 93) n = 6'($urandom_range(21, 32));
    else if (pick < 97) n = 6'($urandom_range(33, 63));
    else                n = '0;
    pick = $urandom_range(0, 9);
    if (pick == 0)      r = '0;
    else if (pick == 1) r = 16'hFFFF;
    else                r = 16'($urandom);
    return make_star(random_coord(), random_coord(), r, n);
  endfunction

  // called at a clock edge; returns at the edge where the request is taken
  task automatic send_star(star_req_t s, int gap, bit hold_for_idle);
    if (gap > 0 || hold_for_idle) begin
      start <= 1'b0;
      if (hold_for_idle) begin
        @(posedge clk);
        while (busy) @(posedge clk);
      end
      repeat (gap) @(posedge clk);
    end
    start    <= 1'b1;
    star_req <= s;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0 || busy) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_scale(logic [15:0] value);
    cfg_wdata <= value;
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    logic [15:0] scale_plan[6];
    int          gap;
    bit          hold;
    bit          steady;

    scale_plan = '{16'h0000, 16'hFFFF, 16'h8000, 16'($urandom), 16'h0001, INNER_SCALE_RESET};
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_star(make_star(24'h000000, 24'h000000, 16'h0000, 6'd1), 0, 0);
    send_star(make_star(24'h000000, 24'h000000, 16'hFFFF, 6'd1), 0, 0);
    send_star(make_star(24'h000100, 24'hFFFF00, 16'h0100, 6'd2), 0, 0);
    send_star(make_star(24'h123456, 24'h654321, 16'hFFFF, 6'd0), 0, 0);
    send_star(make_star(24'h000000, 24'h000000, 16'hFFFF, 6'd32), 3, 0);
    send_star(make_star(24'h001000, 24'hFFF000, 16'h1234, 6'd33), 0, 1);
    send_star(make_star(24'hABCDEF, 24'h543210, 16'hFFFF, 6'd63), 0, 0);
    send_star(make_star(24'h7FFFFF, 24'h800000, 16'hFFFF, 6'd5), 0, 0);
    send_star(make_star(24'h800000, 24'h7FFFFF, 16'hFFFF, 6'd5), 0, 0);
    send_star(make_star(24'h7FFF00, 24'h7FFF00, 16'h8000, 6'd4), 0, 0);
    send_star(make_star(24'h800080, 24'h800080, 16'h8000, 6'd4), 0, 0);
    send_star(make_star(24'h000000, 24'h000000, 16'h0000, 6'd0), 0, 0);
    for (int n = 3; n <= 8; n++) begin
      send_star(make_star(random_coord(), random_coord(), 16'($urandom), 6'(n)), 0, 0);
    end
    send_star(make_star(24'h555555, 24'hAAAAAA, 16'h5555, 6'd16), 0, 0);
    send_star(make_star(24'hAAAAAA, 24'h555555, 16'hAAAA, 6'd31), 0, 0);

    steady = 0;
    foreach (scale_plan[p]) begin
      drain();
      write_scale(scale_plan[p]);
      for (int i = 0; i < 75; i++) begin
        if (i % 16 == 0) steady = ($urandom_range(0, 3) == 0);
        if (steady) begin
          gap  = 0;
          hold = 0;
        end else begin
          gap  = $urandom_range(0, 18);
          hold = ($urandom_range(0, 2) == 0);
          if ($urandom_range(0, 39) == 0) drain();
        end
        send_star(random_star(), gap, hold);
      end
    end

    drain();
    if (fail_count == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
